### src/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the line-search step controller
// Holds the controller states, the multiplier operand selection, the
// command and status groups between controller and datapath, and the codes.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int RATIO_BITS      = 24;
    localparam int KIND_WIDTH      = 3;
    localparam int LIMIT_WIDTH     = 8;
    localparam int BIAS_WIDTH      = 16;
    localparam int COUNT_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    localparam logic [KIND_WIDTH-1:0] TK_ARMIJO       = 3'd0;
    localparam logic [KIND_WIDTH-1:0] TK_GOLDSTEIN    = 3'd1;
    localparam logic [KIND_WIDTH-1:0] TK_WOLFE        = 3'd2;
    localparam logic [KIND_WIDTH-1:0] TK_STRONG_WOLFE = 3'd3;
    localparam logic [KIND_WIDTH-1:0] TK_MOD_ARMIJO   = 3'd4;
    localparam logic [KIND_WIDTH-1:0] TK_MOD_WOLFE    = 3'd5;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUFF_DECREASE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CURVATURE     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REFERENCE     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITER_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIV_BIAS      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MGO,
        S_MWAIT,
        S_TEST,
        S_DGO,
        S_DWAIT,
        S_UPD,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        M_GA,
        M_RGA,
        M_SG,
        M_GL,
        M_P
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        logic  d10_start;
        logic  mul_capture;
        t_msel msel;
        logic  div_start;
        logic  accept_fin;
        logic  step_update;
        logic  emit;
    } t_dp_cmd;

    typedef struct packed {
        logic go_trial;
        logic mul_busy;
        logic d10_busy;
        logic div_busy;
        logic accepted;
        logic den_zero;
        logic out_free;
    } t_dp_stat;

endpackage

### src/bls_mul.sv
// ----------------------------------------------------------------------------
// bls_mul: sequential signed fixed-point multiplier
// Multiplies two signed operands eight multiplier bits per cycle, then
// shifts right with floor rounding and saturates to the value width.
// ----------------------------------------------------------------------------
module bls_mul
    import bls_pkg::*;
#(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24,
    parameter int OP_WIDTH      = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_frac_shift,
    input  logic signed [OP_WIDTH-1:0]    i_a,
    input  logic signed [OP_WIDTH-1:0]    i_b,
    output logic                          o_busy,
    output logic signed [VALUE_WIDTH-1:0] o_result
);

    localparam int W      = VALUE_WIDTH;
    localparam int DIGIT  = 8;
    localparam int DIGITS = (OP_WIDTH + DIGIT - 1) / DIGIT;
    localparam int MBW    = DIGITS * DIGIT;
    localparam int PW     = OP_WIDTH + MBW;
    localparam int CW     = $clog2(DIGITS + 1);

    localparam logic signed [PW:0] SMAX = {{(PW - W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [PW:0] SMIN = {{(PW - W + 2){1'b1}}, {(W - 1){1'b0}}};

    logic [OP_WIDTH-1:0]       r_ma;
    logic [MBW-1:0]            r_mb;
    logic [PW-1:0]             r_acc;
    logic                      r_neg;
    logic                      r_frac;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic [OP_WIDTH-1:0]       a_mag;
    logic [OP_WIDTH-1:0]       b_mag;
    logic [OP_WIDTH+DIGIT-1:0] pp;
    logic signed [PW:0]        sval;
    logic signed [PW:0]        shifted;

    assign a_mag = i_a[OP_WIDTH-1] ? OP_WIDTH'(-i_a) : OP_WIDTH'(i_a);
    assign b_mag = i_b[OP_WIDTH-1] ? OP_WIDTH'(-i_b) : OP_WIDTH'(i_b);
    assign pp    = (OP_WIDTH+DIGIT)'(r_ma) * (OP_WIDTH+DIGIT)'(r_mb[MBW-1 -: DIGIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma   <= a_mag;
            r_mb   <= MBW'(b_mag);
            r_acc  <= '0;
            r_neg  <= i_a[OP_WIDTH-1] ^ i_b[OP_WIDTH-1];
            r_frac <= i_frac_shift;
            r_cnt  <= CW'(DIGITS);
        end else if (r_busy) begin
            r_acc <= (r_acc << DIGIT) + PW'(pp);
            r_mb  <= r_mb << DIGIT;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        sval    = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        shifted = r_frac ? (sval >>> FRACTION_BITS) : (sval >>> RATIO_BITS);
        if (shifted > SMAX) begin
            o_result = SMAX[W-1:0];
        end else if (shifted < SMIN) begin
            o_result = SMIN[W-1:0];
        end else begin
            o_result = shifted[W-1:0];
        end
    end

    assign o_busy = r_busy;

endmodule

### src/bls_div.sv
// ----------------------------------------------------------------------------
// bls_div: restoring divider for the interpolation quotient
// Divides a magnitude scaled by the fraction bits by a non-zero divisor,
// producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bls_div
    import bls_pkg::*;
#(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [VALUE_WIDTH-1:0]                 i_num,
    input  logic [VALUE_WIDTH-1:0]                 i_den,
    output logic                                   o_busy,
    output logic [VALUE_WIDTH+FRACTION_BITS-1:0]   o_quot
);

    localparam int W  = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    trial;
    logic          ge;

    assign trial = {r_r, r_n[NW-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {i_num, {FRACTION_BITS{1'b0}}};
            r_q   <= '0;
            r_r   <= '0;
            r_d   <= i_den;
            r_cnt <= CW'(NW);
        end else if (r_busy) begin
            r_n   <= r_n << 1;
            r_q   <= {r_q[NW-2:0], ge};
            r_r   <= ge ? W'(trial - {1'b0, r_d}) : trial[W-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

### src/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl: sequencing controller of the line-search step
// Walks one beat through the multiplications, the acceptance test, the
// interpolation divide and the result write.
// ----------------------------------------------------------------------------
module bls_ctrl
    import bls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_msel  r_msel;
    t_msel  n_msel;
    logic   mul_idle;

    assign mul_idle = !i_stat.mul_busy && !i_stat.d10_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msel  <= M_GA;
        end else begin
            r_state <= n_state;
            r_msel  <= n_msel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_msel  = r_msel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.go_trial) begin
                        n_state = S_MGO;
                        n_msel  = M_GA;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MGO: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_idle) begin
                    case (r_msel)
                        M_GA: begin
                            n_msel  = M_RGA;
                            n_state = S_MGO;
                        end
                        M_RGA: begin
                            n_msel  = M_SG;
                            n_state = S_MGO;
                        end
                        M_SG: begin
                            n_msel  = M_GL;
                            n_state = S_MGO;
                        end
                        M_GL: begin
                            n_state = S_TEST;
                        end
                        default: begin
                            n_state = i_stat.den_zero ? S_UPD : S_DGO;
                        end
                    endcase
                end
            end
            S_TEST: begin
                if (i_stat.accepted) begin
                    n_state = S_EMIT;
                end else begin
                    n_msel  = M_P;
                    n_state = S_MGO;
                end
            end
            S_DGO: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = r_state == S_IDLE;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_start   = r_state == S_MGO;
        o_cmd.d10_start   = (r_state == S_MGO) && (r_msel == M_P);
        o_cmd.mul_capture = (r_state == S_MWAIT) && mul_idle;
        o_cmd.msel        = r_msel;
        o_cmd.div_start   = r_state == S_DGO;
        o_cmd.accept_fin  = (r_state == S_TEST) && i_stat.accepted;
        o_cmd.step_update = r_state == S_UPD;
        o_cmd.emit        = (r_state == S_EMIT) && i_stat.out_free;
    end

endmodule

### src/bls_dp.sv
// ----------------------------------------------------------------------------
// bls_dp: datapath of the line-search step
// Holds the configuration and search state, the operand selection of the
// shared multiplier, the acceptance tests, the step clamp and the result.
// ----------------------------------------------------------------------------
module bls_dp
    import bls_pkg::*;
#(
    parameter int VALUE_WIDTH    = 48,
    parameter int FRACTION_BITS  = 24,
    parameter int OP_WIDTH       = 48,
    parameter int CFG_DATA_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic                          i_op,
    input  logic signed [VALUE_WIDTH-1:0] i_function_value,
    input  logic signed [VALUE_WIDTH-1:0] i_slope,
    input  logic [VALUE_WIDTH-2:0]        i_first_step,
    input  logic [KIND_WIDTH-1:0]         i_test_kind,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [VALUE_WIDTH-2:0]        o_step,
    output logic                          o_done_res,
    output logic                          o_success,
    output logic [COUNT_WIDTH-1:0]        o_evaluations,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam int W     = VALUE_WIDTH;
    localparam int NW    = VALUE_WIDTH + FRACTION_BITS;
    localparam int XW    = VALUE_WIDTH + 3;
    localparam int D10W  = ((VALUE_WIDTH - 1 + 3) / 4) * 4;
    localparam int D10S  = D10W / 4;
    localparam int D10CW = $clog2(D10S + 1);

    localparam logic signed [XW-1:0] VMAX = {4'b0000, {(W - 1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN = {4'b1111, {(W - 1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [W-1:0] y;
        if (x > VMAX) begin
            y = VMAX[W-1:0];
        end else if (x < VMIN) begin
            y = VMIN[W-1:0];
        end else begin
            y = x[W-1:0];
        end
        return y;
    endfunction

    logic [RATIO_BITS:0]      r_rho;
    logic [RATIO_BITS:0]      r_sigma;
    logic signed [W-1:0]      r_cref;
    logic [LIMIT_WIDTH-1:0]   r_limit;
    logic [BIAS_WIDTH-1:0]    r_bias;
    logic signed [W-1:0]      r_f0;
    logic signed [W-1:0]      r_g0;
    logic [W-2:0]             r_a;
    logic [KIND_WIDTH-1:0]    r_mode;
    logic [LIMIT_WIDTH-1:0]   r_tcount;
    logic                     r_active;
    logic [COUNT_WIDTH-1:0]   r_evals;
    logic                     r_res_done;
    logic                     r_res_ok;
    logic                     r_out_valid;
    logic signed [W-1:0]      r_fn;
    logic signed [W-1:0]      r_gn;
    logic signed [W-1:0]      r_ga;
    logic signed [W-1:0]      r_rga;
    logic signed [W-1:0]      r_sg;
    logic signed [W-1:0]      r_gl;
    logic signed [W-1:0]      r_p;
    logic [W-2:0]             r_out_step;
    logic                     r_out_done;
    logic                     r_out_ok;
    logic [COUNT_WIDTH-1:0]   r_out_evals;
    logic [D10W-1:0]          r_d10_n;
    logic [D10W-1:0]          r_d10_q;
    logic [3:0]               r_d10_r;
    logic [D10CW-1:0]         r_d10_cnt;
    logic                     r_d10_busy;

    logic signed [OP_WIDTH-1:0]      mul_a;
    logic signed [OP_WIDTH-1:0]      mul_b;
    logic                            mul_frac;
    logic                            mul_busy;
    logic signed [W-1:0]             mul_res;
    logic signed [RATIO_BITS+1:0]    omr;
    logic                            arm;
    logic                            marm;
    logic                            gold;
    logic                            wolfe;
    logic                            swolfe;
    logic                            accepted;
    logic signed [XW-1:0]            neg_sg;
    logic signed [W-1:0]             den;
    logic                            den_neg;
    logic [W-1:0]                    den_mag;
    logic signed [W-1:0]             num;
    logic                            num_neg;
    logic [W-1:0]                    num_mag;
    logic                            div_busy;
    logic [NW-1:0]                   quot;
    logic [W-2:0]                    lo_b;
    logic [W-2:0]                    hi_b;
    logic [W-2:0]                    new_step;
    logic [LIMIT_WIDTH-1:0]          lim;
    logic                            limit_hit;
    logic [COUNT_WIDTH-1:0]          evals_inc;
    logic [3:0]                      d10_r_next;
    logic [3:0]                      d10_q_bits;
    logic                            out_free;

    assign omr = $signed({2'b01, {RATIO_BITS{1'b0}}}) - $signed({1'b0, r_rho});

    always_comb begin
        mul_a    = OP_WIDTH'(r_g0);
        mul_b    = OP_WIDTH'(r_a);
        mul_frac = 1'b1;
        case (i_cmd.msel)
            M_GA: begin
                mul_a    = OP_WIDTH'(r_g0);
                mul_b    = OP_WIDTH'(r_a);
                mul_frac = 1'b1;
            end
            M_RGA: begin
                mul_a    = OP_WIDTH'(r_ga);
                mul_b    = OP_WIDTH'(r_rho);
                mul_frac = 1'b0;
            end
            M_SG: begin
                mul_a    = OP_WIDTH'(r_g0);
                mul_b    = OP_WIDTH'(r_sigma);
                mul_frac = 1'b0;
            end
            M_GL: begin
                mul_a    = OP_WIDTH'(r_ga);
                mul_b    = OP_WIDTH'(omr);
                mul_frac = 1'b0;
            end
            M_P: begin
                mul_a    = OP_WIDTH'(r_a);
                mul_b    = OP_WIDTH'(r_ga);
                mul_frac = 1'b1;
            end
            default: begin
                mul_frac = 1'b1;
            end
        endcase
    end

    bls_mul #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .OP_WIDTH      (OP_WIDTH)
    ) u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.mul_start),
        .i_frac_shift (mul_frac),
        .i_a          (mul_a),
        .i_b          (mul_b),
        .o_busy       (mul_busy),
        .o_result     (mul_res)
    );

    // Acceptance tests on the captured products.
    always_comb begin
        neg_sg = -XW'(r_sg);
        arm    = !(sat_w(XW'(r_f0) + XW'(r_rga)) < r_fn);
        marm   = !(sat_w(XW'(r_cref) + XW'(r_rga)) < r_fn);
        gold   = !(r_fn < sat_w(XW'(r_f0) + XW'(r_gl)));
        wolfe  = !(r_gn < r_sg);
        swolfe = !(neg_sg < XW'(r_gn));
        case (r_mode)
            TK_ARMIJO:       accepted = arm;
            TK_GOLDSTEIN:    accepted = arm && gold;
            TK_WOLFE:        accepted = arm && wolfe;
            TK_STRONG_WOLFE: accepted = arm && wolfe && swolfe;
            TK_MOD_ARMIJO:   accepted = marm;
            TK_MOD_WOLFE:    accepted = marm && wolfe;
            default:         accepted = 1'b0;
        endcase
    end

    // Interpolation numerator and denominator.
    always_comb begin
        den = sat_w(XW'(r_fn) - XW'(r_f0) - XW'(r_ga) + $signed(XW'(r_bias)));
        den_neg = den[W-1];
        den_mag = den_neg ? W'(-den) : W'(den);
        num     = -(r_p >>> 1);
        num_neg = num[W-1];
        num_mag = num_neg ? W'(-num) : W'(num);
    end

    bls_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_comb begin
        lo_b = r_d10_q[W-2:0];
        hi_b = r_a >> 1;
        if (den == '0) begin
            new_step = lo_b;
        end else if (quot != '0 && num_neg != den_neg) begin
            new_step = lo_b;
        end else if (quot < NW'(lo_b)) begin
            new_step = lo_b;
        end else if (quot > NW'(hi_b)) begin
            new_step = hi_b;
        end else begin
            new_step = quot[W-2:0];
        end
    end

    // Division of the step by ten, four bits per cycle.
    always_comb begin
        logic [4:0] t;
        logic [3:0] rr;
        rr = r_d10_r;
        d10_q_bits = '0;
        for (int k = 0; k < 4; k++) begin
            t = {rr, r_d10_n[D10W-1-k]};
            d10_q_bits[3-k] = t >= 5'd10;
            rr = (t >= 5'd10) ? 4'(t - 5'd10) : t[3:0];
        end
        d10_r_next = rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d10_busy <= 1'b0;
        end else if (i_cmd.d10_start) begin
            r_d10_busy <= 1'b1;
        end else if (r_d10_busy && r_d10_cnt == D10CW'(1)) begin
            r_d10_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.d10_start) begin
            r_d10_n   <= D10W'(r_a);
            r_d10_q   <= '0;
            r_d10_r   <= '0;
            r_d10_cnt <= D10CW'(D10S);
        end else if (r_d10_busy) begin
            r_d10_n   <= r_d10_n << 4;
            r_d10_q   <= {r_d10_q[D10W-5:0], d10_q_bits};
            r_d10_r   <= d10_r_next;
            r_d10_cnt <= r_d10_cnt - D10CW'(1);
        end
    end

    assign lim       = (r_limit == '0) ? LIMIT_WIDTH'(1) : r_limit;
    assign limit_hit = r_tcount >= lim;
    assign evals_inc = (r_evals == '1) ? r_evals : r_evals + COUNT_WIDTH'(1);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho   <= (RATIO_BITS+1)'(1678);
            r_sigma <= (RATIO_BITS+1)'(15099494);
            r_cref  <= '0;
            r_limit <= LIMIT_WIDTH'(15);
            r_bias  <= BIAS_WIDTH'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SUFF_DECREASE: r_rho   <= i_cfg_data[RATIO_BITS:0];
                CFG_CURVATURE:     r_sigma <= i_cfg_data[RATIO_BITS:0];
                CFG_REFERENCE:     r_cref  <= i_cfg_data[W-1:0];
                CFG_ITER_LIMIT:    r_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_DIV_BIAS:      r_bias  <= i_cfg_data[BIAS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0       <= '0;
            r_g0       <= '0;
            r_a        <= '0;
            r_mode     <= '0;
            r_tcount   <= '0;
            r_active   <= 1'b0;
            r_evals    <= '0;
            r_res_done <= 1'b0;
            r_res_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_op == OP_START) begin
                    r_f0       <= i_function_value;
                    r_g0       <= i_slope;
                    r_a        <= i_first_step;
                    r_mode     <= i_test_kind;
                    r_tcount   <= '0;
                    r_active   <= 1'b1;
                    r_evals    <= evals_inc;
                    r_res_done <= 1'b0;
                    r_res_ok   <= 1'b0;
                end else if (r_active) begin
                    r_evals  <= evals_inc;
                    r_tcount <= r_tcount + LIMIT_WIDTH'(1);
                end else begin
                    r_res_done <= 1'b1;
                    r_res_ok   <= 1'b0;
                end
            end
            if (i_cmd.accept_fin) begin
                r_res_done <= 1'b1;
                r_res_ok   <= 1'b1;
                r_active   <= 1'b0;
            end
            if (i_cmd.step_update) begin
                r_a        <= new_step;
                r_res_done <= limit_hit;
                r_res_ok   <= limit_hit && (r_fn < r_f0);
                if (limit_hit) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fn <= i_function_value;
            r_gn <= i_slope;
        end
        if (i_cmd.mul_capture) begin
            case (i_cmd.msel)
                M_GA:    r_ga  <= mul_res;
                M_RGA:   r_rga <= mul_res;
                M_SG:    r_sg  <= mul_res;
                M_GL:    r_gl  <= mul_res;
                M_P:     r_p   <= mul_res;
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_out_step  <= r_a;
            r_out_done  <= r_res_done;
            r_out_ok    <= r_res_ok;
            r_out_evals <= r_evals;
        end
    end

    always_comb begin
        o_stat.go_trial = (i_op == OP_TRIAL) && r_active;
        o_stat.mul_busy = mul_busy;
        o_stat.d10_busy = r_d10_busy;
        o_stat.div_busy = div_busy;
        o_stat.accepted = accepted;
        o_stat.den_zero = den == '0;
        o_stat.out_free = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_step        = r_out_step;
    assign o_done_res    = r_out_done;
    assign o_success     = r_out_ok;
    assign o_evaluations = r_out_evals;

endmodule

### src/backtracking_line_search_step_top.sv
// ----------------------------------------------------------------------------
// backtracking_line_search_step_top: backtracking line-search step controller
// Decides acceptance of a trial step and proposes the next step by clamped
// quadratic interpolation, in saturating signed fixed point.
// ----------------------------------------------------------------------------
// Usage: a start beat on the input channel opens a search with f, slope,
// first step and test kind; every trial beat carries f and the slope at the
// step last proposed. Each input beat yields exactly one output beat with the
// step, the done and success flags and the evaluation count.
// Start beats and trials without an open search go from idle straight to the
// result write. A trial that passes its test takes four passes through the
// shared multiplier (start, the multiplier bits eight at a time, capture), then
// the test and the write. A rejected trial takes a fifth pass, held until the
// division of the step by ten is also done, then the restoring divider, which
// yields one of VALUE_WIDTH + FRACTION_BITS quotient bits a cycle; with a zero
// divisor the divider is skipped.
// One beat is in work at a time; the next is taken once the result is written.
// The output register holds a result while the receiver stalls; the next
// input beat is still taken, and its result waits until the register frees.
// Configuration writes are taken in any cycle and must only come while idle.
// After reset all search state is cleared and the registers take their
// default values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module backtracking_line_search_step_top
    import bls_pkg::*;
#(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [VALUE_WIDTH-1:0] i_function_value,
    input  logic signed [VALUE_WIDTH-1:0] i_slope,
    input  logic [VALUE_WIDTH-2:0]        i_first_step,
    input  logic [KIND_WIDTH-1:0]         i_test_kind,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [VALUE_WIDTH-2:0]        o_step,
    output logic                          o_done_res,
    output logic                          o_success,
    output logic [COUNT_WIDTH-1:0]        o_evaluations,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [((VALUE_WIDTH > RATIO_BITS + 1) ? VALUE_WIDTH : RATIO_BITS + 1)-1:0]
                                          i_cfg_data
);

    localparam int CFG_DATA_WIDTH =
        (VALUE_WIDTH > RATIO_BITS + 1) ? VALUE_WIDTH : RATIO_BITS + 1;
    localparam int OP_WIDTH =
        (VALUE_WIDTH > RATIO_BITS + 2) ? VALUE_WIDTH : RATIO_BITS + 2;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bls_dp #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .FRACTION_BITS  (FRACTION_BITS),
        .OP_WIDTH       (OP_WIDTH),
        .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_op             (i_op),
        .i_function_value (i_function_value),
        .i_slope          (i_slope),
        .i_first_step     (i_first_step),
        .i_test_kind      (i_test_kind),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_step           (o_step),
        .o_done_res       (o_done_res),
        .o_success        (o_success),
        .o_evaluations    (o_evaluations),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken again straight after a beat was accepted.");

    a_mul_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_start |=> w_stat.mul_busy)
        else $error("Multiplier did not start on command.");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("Output beat appeared without a result write.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !w_cmd.emit)
        else $error("Pending output beat overwritten.");
`endif

endmodule

### verif/tb_backtracking_line_search_step_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_backtracking_line_search_step_top: self-checking bench of the line search
// A directed table and then random searches, mostly well-formed start and
// trial sequences, are sent while both channels idle and stall at random.
// Each output beat is compared with the expected result, taken from the table or worked out by a predictor.
// ----------------------------------------------------------------------------
module tb_backtracking_line_search_step_top;
    import bls_pkg::*;

    localparam int VW = 48;
    localparam int FB = 24;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic                 op;
        logic signed [VW-1:0] fv;
        logic signed [VW-1:0] sl;
        logic [VW-2:0]        fs;
        logic [2:0]           kind;
    } t_beat;

    typedef struct {
        logic [VW-2:0] step;
        logic          done;
        logic          succ;
        logic [15:0]   evals;
    } t_outcome;

    typedef struct {
        t_beat    b;
        bit       known;
        t_outcome o;
    } t_row;

    localparam t_wide VMAX = (t_wide'(1) <<< (VW - 1)) - 1;
    localparam t_wide VMIN = -(t_wide'(1) <<< (VW - 1));
    localparam logic signed [VW-1:0] FMAX = VMAX[VW-1:0];
    localparam logic signed [VW-1:0] FMIN = VMIN[VW-1:0];
    localparam logic [VW-2:0] SMAX = '1;
    localparam logic signed [VW-1:0] ONE = 48'sd16777216;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_op;
    logic signed [VW-1:0] i_function_value;
    logic signed [VW-1:0] i_slope;
    logic [VW-2:0]     i_first_step;
    logic [KIND_WIDTH-1:0] i_test_kind;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [VW-2:0]     o_step;
    logic              o_done_res;
    logic              o_success;
    logic [COUNT_WIDTH-1:0] o_evaluations;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [VW-1:0]     i_cfg_data;

    // Predictor state and register copies.
    logic signed [VW-1:0] base_value, base_slope, ref_c;
    logic [VW-2:0]        cur_step;
    logic [2:0]           cur_kind;
    logic [7:0]           tries, max_tries;
    logic                 searching;
    logic [15:0]          eval_count, bias;
    logic [24:0]          rho, sigma;

    t_outcome step_q[$];
    t_row     table_rows[$];
    int       failures = 0;
    int       burst_left = 0;
    bit       hold_req = 0;

    backtracking_line_search_step_top i_dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_wide sat_v(t_wide x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    function automatic t_wide mulq(t_wide a, t_wide b, int sh);
        return sat_v((a * b) >>> sh);
    endfunction

    function automatic bit step_accepted(t_wide fn, t_wide gn);
        t_wide a, g, f0, ga, rga, sg, omr, cref;
        bit arm, marm, wolfe;
        a = t_wide'({1'b0, cur_step});
        g = t_wide'(base_slope);
        f0 = t_wide'(base_value);
        ga = mulq(g, a, FB);
        rga = mulq(ga, t_wide'({1'b0, rho}), RATIO_BITS);
        sg = mulq(g, t_wide'({1'b0, sigma}), RATIO_BITS);
        omr = (t_wide'(1) <<< RATIO_BITS) - t_wide'({1'b0, rho});
        cref = t_wide'(ref_c);
        arm = !(sat_v(f0 + rga) < fn);
        marm = !(sat_v(cref + rga) < fn);
        wolfe = !(gn < sg);
        case (cur_kind)
            TK_ARMIJO:       return arm;
            TK_GOLDSTEIN:    return arm && !(fn < sat_v(f0 + mulq(ga, omr, RATIO_BITS)));
            TK_WOLFE:        return arm && wolfe;
            TK_STRONG_WOLFE: return arm && wolfe && !(-sg < gn);
            TK_MOD_ARMIJO:   return marm;
            TK_MOD_WOLFE:    return marm && wolfe;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic logic [VW-2:0] interpolated_step(t_wide fn);
        t_wide a, f0, ga, lo_b, hi_b, den, num;
        logic [127:0] n, dmag, q;
        a = t_wide'({1'b0, cur_step});
        f0 = t_wide'(base_value);
        ga = mulq(t_wide'(base_slope), a, FB);
        lo_b = a / 10;
        hi_b = a >>> 1;
        den = sat_v(fn - f0 - ga + t_wide'({1'b0, bias}));
        if (den == 0) return lo_b[VW-2:0];
        num = -(mulq(a, ga, FB) >>> 1);
        n = (num < 0 ? -num : num) << FB;
        dmag = den < 0 ? -den : den;
        q = n / dmag;
        if (q != 0 && ((num < 0) != (den < 0))) return lo_b[VW-2:0];
        if (q < $unsigned(lo_b)) return lo_b[VW-2:0];
        if (q > $unsigned(hi_b)) return hi_b[VW-2:0];
        return q[VW-2:0];
    endfunction

    task automatic predict_outcome(input t_beat b, output t_outcome r);
        logic [7:0] lim;
        t_wide fn, gn;
        r.done = 1'b0;
        r.succ = 1'b0;
        if (b.op == OP_START) begin
            base_value = b.fv;
            base_slope = b.sl;
            cur_step = b.fs;
            cur_kind = b.kind;
            tries = '0;
            searching = 1'b1;
            if (eval_count != 16'hffff) eval_count++;
        end else if (!searching) begin
            r.done = 1'b1;
        end else begin
            fn = t_wide'(b.fv);
            gn = t_wide'(b.sl);
            lim = (max_tries == 0) ? 8'd1 : max_tries;
            if (eval_count != 16'hffff) eval_count++;
            tries++;
            if (step_accepted(fn, gn)) begin
                r.done = 1'b1;
                r.succ = 1'b1;
                searching = 1'b0;
            end else begin
                cur_step = interpolated_step(fn);
                if (tries >= lim) begin
                    r.done = 1'b1;
                    r.succ = fn < t_wide'(base_value);
                    searching = 1'b0;
                end
            end
        end
        r.step = cur_step;
        r.evals = eval_count;
    endtask

    task automatic send_beat(input t_beat b, input bit known, input t_outcome o);
        t_outcome r;
        int gap;
        i_op <= b.op;
        i_function_value <= b.fv;
        i_slope <= b.sl;
        i_first_step <= b.fs;
        i_test_kind <= b.kind;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_outcome(b, r);
        step_q.push_back(known ? o : r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (step_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [VW-1:0] d);
        i_cfg_index <= idx;
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SUFF_DECREASE: rho = d[24:0];
            CFG_CURVATURE:     sigma = d[24:0];
            CFG_REFERENCE:     ref_c = d;
            CFG_ITER_LIMIT:    max_tries = d[7:0];
            CFG_DIV_BIAS:      bias = d[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [24:0] r, input logic [24:0] s,
                             input logic [VW-1:0] c, input logic [7:0] l,
                             input logic [15:0] bi);
        write_reg(CFG_SUFF_DECREASE, VW'(r));
        write_reg(CFG_CURVATURE, VW'(s));
        write_reg(CFG_REFERENCE, c);
        write_reg(CFG_ITER_LIMIT, VW'(l));
        write_reg(CFG_DIV_BIAS, VW'(bi));
    endtask

    function automatic logic signed [VW-1:0] rand_value();
        t_wide v;
        case ($urandom_range(0, 7))
            0: return FMAX;
            1: return FMIN;
            2: return VW'({$urandom(), $urandom()});
            default: begin
                v = t_wide'($urandom() >> $urandom_range(0, 31)) <<< $urandom_range(0, 12);
                return VW'($urandom_range(0, 1) ? -v : v);
            end
        endcase
    endfunction

    function automatic t_beat start_beat();
        t_beat b;
        b.op = OP_START;
        b.fv = rand_value();
        b.sl = ($urandom_range(0, 4) == 0) ? rand_value()
                                           : -$signed(VW'($urandom_range(1, 1 << 27)));
        b.fs = ($urandom_range(0, 6) == 0) ? (VW-1)'({$urandom(), $urandom()})
                                           : (VW-1)'($urandom_range(1 << 18, 1 << 27));
        b.kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
        return b;
    endfunction

    function automatic t_beat trial_beat();
        t_beat b;
        t_wide ga;
        ga = mulq(t_wide'(base_slope), t_wide'({1'b0, cur_step}), FB);
        b.op = OP_TRIAL;
        b.fs = (VW-1)'({$urandom(), $urandom()});
        b.kind = 3'($urandom_range(0, 7));
        b.fv = VW'(sat_v(t_wide'(base_value) + ga * (int'($urandom_range(0, 16)) - 6) / 8
                         + int'($urandom_range(0, 64)) - 32));
        b.sl = ($urandom_range(0, 5) == 0) ? rand_value()
             : VW'(sat_v(t_wide'(base_slope) * (int'($urandom_range(0, 48)) - 24) / 16));
        return b;
    endfunction

    function automatic t_beat noise_beat();
        t_beat b;
        b.op = 1'($urandom_range(0, 1));
        b.fv = VW'({$urandom(), $urandom()});
        b.sl = VW'({$urandom(), $urandom()});
        b.fs = (VW-1)'({$urandom(), $urandom()});
        b.kind = 3'($urandom_range(0, 7));
        return b;
    endfunction

    task automatic add_row(input t_beat b, input bit known, input t_outcome o);
        t_row r;
        r.b = b;
        r.known = known;
        r.o = o;
        table_rows.push_back(r);
    endtask

    function automatic t_beat mk(logic op, logic signed [VW-1:0] f, logic signed [VW-1:0] s,
                                 logic [VW-2:0] st, logic [2:0] k);
        t_beat b;
        b.op = op;
        b.fv = f;
        b.sl = s;
        b.fs = st;
        b.kind = k;
        return b;
    endfunction

    task automatic build_table();
        t_outcome none;
        logic [2:0] k;
        none = '{default: '0};
        add_row(mk(OP_TRIAL, FMAX, FMIN, SMAX, 3'd7), 1, '{'0, 1'b1, 1'b0, 16'd0});
        add_row(mk(OP_START, FMAX, FMIN, SMAX, 3'd7), 1, '{SMAX, 1'b0, 1'b0, 16'd1});
        add_row(mk(OP_TRIAL, FMIN, FMAX, '0, 3'd0), 0, none);
        add_row(mk(OP_START, '0, '0, 47'd16777216, 3'd6), 1,
                '{47'd16777216, 1'b0, 1'b0, 16'd3});
        // A zero interpolation divisor: the step falls to a tenth.
        add_row(mk(OP_TRIAL, -48'sd1, '0, '0, 3'd0), 0, none);
        // Rising slope gives a negative quotient.
        add_row(mk(OP_START, ONE, ONE, 47'd16777216, TK_ARMIJO), 0, none);
        add_row(mk(OP_TRIAL, ONE * 8, '0, '0, 3'd0), 0, none);
        for (int i = 0; i < 6; i++) begin
            k = 3'(i);
            add_row(mk(OP_START, '0, -ONE, 47'd16777216, k), 0, none);
            add_row(mk(OP_TRIAL, -(ONE / 2), '0, '0, 3'd0), 0, none);
        end
        add_row(mk(OP_TRIAL, '0, '0, '0, 3'd0), 0, none);
        add_row(mk(OP_START, FMIN, FMAX, '0, 3'd0), 0, none);
        add_row(mk(OP_TRIAL, FMAX, FMIN, '0, 3'd0), 0, none);
    endtask

    task automatic run_random(input int n);
        int sent, len;
        t_outcome none;
        none = '{default: '0};
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(noise_beat(), 0, none);
                sent++;
            end else begin
                send_beat(start_beat(), 0, none);
                sent++;
                len = $urandom_range(1, 25);
                while (searching && len > 0 && sent < n) begin
                    send_beat(trial_beat(), 0, none);
                    sent++;
                    len--;
                end
            end
        end
    endtask

    initial begin
        int mode, mode_left;
        mode = 0;
        mode_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                i_out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) < mode);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (step_q.size() == 0) begin
                $error("output beat with no result pending");
                failures++;
            end else begin
                e = step_q.pop_front();
                if (o_step !== e.step) begin
                    $error("step: expected %0d, got %0d", e.step, o_step);
                    failures++;
                end
                if (o_done_res !== e.done) begin
                    $error("done_res: expected %0d, got %0d", e.done, o_done_res);
                    failures++;
                end
                if (o_success !== e.succ) begin
                    $error("success: expected %0d, got %0d", e.succ, o_success);
                    failures++;
                end
                if (o_evaluations !== e.evals) begin
                    $error("evaluations: expected %0d, got %0d", e.evals, o_evaluations);
                    failures++;
                end
            end
        end
    end

    initial begin
        #(12 * 900000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_START;
        i_function_value <= '0;
        i_slope <= '0;
        i_first_step <= '0;
        i_test_kind <= TK_ARMIJO;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SUFF_DECREASE;
        i_cfg_data <= '0;
        rho = 25'd1678;
        sigma = 25'd15099494;
        ref_c = '0;
        max_tries = 8'd15;
        bias = 16'd1;
        base_value = '0;
        base_slope = '0;
        cur_step = '0;
        cur_kind = '0;
        tries = '0;
        searching = 1'b0;
        eval_count = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        foreach (table_rows[i]) send_beat(table_rows[i].b, table_rows[i].known, table_rows[i].o);
        run_random(90);
        wait_drained();

        write_all(25'd0, 25'd0, VW'(FMIN), 8'd1, 16'd0);
        run_random(120);
        wait_drained();

        write_all(25'd16777216, 25'd16777216, VW'(FMAX), 8'd255, 16'd65535);
        hold_req = 1;
        run_random(60);
        wait_drained();
        run_random(60);
        wait_drained();

        write_all(25'd1678, 25'd15099494, '0, 8'd0, 16'd1);
        run_random(130);
        wait_drained();

        write_all(25'($urandom_range(0, 1 << 24)), 25'($urandom_range(0, 1 << 24)),
                  VW'(rand_value()), 8'($urandom_range(1, 255)),
                  16'($urandom_range(0, 65535)));
        run_random(130);
        wait_drained();

        write_all(25'($urandom_range(0, 1 << 24)), 25'($urandom_range(0, 1 << 24)),
                  VW'(rand_value()), 8'd3, 16'($urandom_range(0, 65535)));
        run_random(130);
        wait_drained();

        repeat (200) @(posedge i_clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### backtracking_line_search_step_top.f
src/bls_pkg.sv
src/bls_mul.sv
src/bls_div.sv
src/bls_ctrl.sv
src/bls_dp.sv
src/backtracking_line_search_step_top.sv
verif/tb_backtracking_line_search_step_top.sv
